>>> design/bpa_pkg.sv
// buddy page allocator: shared constants and types
// no dependencies
package bpa_pkg;

  localparam int PAGES    = 4096;
  localparam int PAGE_W   = $clog2(PAGES);
  localparam int LINK_W   = PAGE_W + 1;
  localparam int ORDERS   = 11;
  localparam int ORD_W    = 4;
  localparam int END_W    = LINK_W + 1;
  localparam int CIDX_W   = 2;
  localparam int CDATA_W  = 13;

  localparam logic [LINK_W-1:0] EMPTY = LINK_W'(PAGES);
  localparam logic [ORD_W-1:0]  ORD_MAX = ORD_W'(ORDERS - 1);

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_BAD_ORD = 2'd2
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_ZONE_FIRST = 2'd0,
    REG_ZONE_COUNT = 2'd1,
    REG_TOP_ORDER  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic               free_head;
    logic [ORD_W-1:0]   order;
  } meta_t;

  typedef struct packed {
    action_t            action;
    logic [ORD_W-1:0]   block_order;
    logic [PAGE_W-1:0]  page_number;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  zone_first_page;
    logic [LINK_W-1:0]  zone_page_count;
    logic [ORD_W-1:0]   top_order;
  } cfg_t;

  typedef struct packed {
    status_t            status;
    logic [PAGE_W-1:0]  granted_page;
    logic [LINK_W-1:0]  free_page_total;
  } res_t;

endpackage

>>> design/bpa_ram.sv
// buddy page allocator: generic single write, single read ram
// read data registered; no dependencies
module bpa_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 13,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/bpa_engine.sv
// buddy page allocator: sequencer over the link and page metadata rams
// depends on bpa_pkg and bpa_ram
module bpa_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  bpa_pkg::req_t  req,
  input  bpa_pkg::cfg_t  cfg,
  output logic           idle,
  output logic           res_valid,
  input  logic           res_ready,
  output bpa_pkg::res_t  res
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_SCAN, S_A_POP, S_A_SPLIT, S_F_CHK, S_F_META,
    S_U_STEP, S_U_READ, S_U_CLR, S_F_TRIM, S_F_PUSH, S_DONE
  } state_t;

  state_t state;

  logic [bpa_pkg::ORD_W-1:0]  ord, tgt, top_eff;
  logic [bpa_pkg::PAGE_W-1:0] pg, bud, clr_cnt;
  logic [bpa_pkg::LINK_W-1:0] cur, prev, steps, total;
  logic [bpa_pkg::END_W-1:0]  zend;
  bpa_pkg::status_t           res_status;
  logic [bpa_pkg::PAGE_W-1:0] res_page;

  logic [bpa_pkg::LINK_W-1:0] heads [bpa_pkg::ORDERS];
  logic [bpa_pkg::LINK_W-1:0] lens  [bpa_pkg::ORDERS];

  logic                        link_we, meta_we;
  logic [bpa_pkg::PAGE_W-1:0]  link_waddr, link_raddr, meta_waddr, meta_raddr;
  logic [bpa_pkg::LINK_W-1:0]  link_wdata, link_rdata;
  bpa_pkg::meta_t              meta_wdata, meta_rdata;

  logic [bpa_pkg::ORD_W-1:0]  oi;
  logic [bpa_pkg::LINK_W-1:0] osize, head_o, len_o, split_pg;
  logic [bpa_pkg::PAGE_W-1:0] bud_c, base_c;
  logic [bpa_pkg::END_W-1:0]  zsum, zend_c, span2, trim_end;
  logic                       bud_ok;
  logic [bpa_pkg::ORD_W-1:0]  top_c;

  bpa_ram #(.DEPTH(bpa_pkg::PAGES), .WIDTH(bpa_pkg::LINK_W)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  bpa_ram #(.DEPTH(bpa_pkg::PAGES), .WIDTH($bits(bpa_pkg::meta_t))) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata)
  );

  always_comb begin
    oi       = (ord > bpa_pkg::ORD_MAX) ? bpa_pkg::ORD_MAX : ord;
    osize    = bpa_pkg::LINK_W'(1) << ord;
    head_o   = heads[oi];
    len_o    = lens[oi];
    split_pg = {1'b0, pg} + osize;
    bud_c    = pg ^ bpa_pkg::PAGE_W'(osize);
    base_c   = (bud_c < pg) ? bud_c : pg;
    span2    = {2'b00, base_c} + (bpa_pkg::END_W'(1) << (ord + 1'b1));
    trim_end = {2'b00, pg} + {1'b0, osize};
    bud_ok   = ({1'b0, bud_c} >= {1'b0, cfg.zone_first_page}) &&
               ({2'b00, bud_c} < zend) && (span2 <= zend);
    zsum     = bpa_pkg::END_W'(cfg.zone_first_page) + bpa_pkg::END_W'(cfg.zone_page_count);
    zend_c   = (zsum > bpa_pkg::END_W'(bpa_pkg::PAGES)) ?
               bpa_pkg::END_W'(bpa_pkg::PAGES) : zsum;
    top_c    = (cfg.top_order > bpa_pkg::ORD_MAX) ? bpa_pkg::ORD_MAX : cfg.top_order;
  end

  // ram port control
  always_comb begin
    link_we    = 1'b0;
    link_waddr = pg;
    link_wdata = bpa_pkg::EMPTY;
    link_raddr = pg;
    meta_we    = 1'b0;
    meta_waddr = pg;
    meta_wdata = '0;
    meta_raddr = bud_c;
    unique case (state)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_cnt;
      end
      S_A_SCAN: begin
        link_raddr = head_o[bpa_pkg::PAGE_W-1:0];
        meta_raddr = head_o[bpa_pkg::PAGE_W-1:0];
      end
      S_A_POP: begin
        link_we    = 1'b1;
        meta_we    = 1'b1;
        meta_wdata = '{free_head: 1'b0, order: (pg == '0) ? meta_rdata.order : tgt};
      end
      S_A_SPLIT: begin
        link_we    = ~split_pg[bpa_pkg::PAGE_W];
        link_waddr = split_pg[bpa_pkg::PAGE_W-1:0];
        link_wdata = head_o;
        meta_we    = ~split_pg[bpa_pkg::PAGE_W];
        meta_waddr = split_pg[bpa_pkg::PAGE_W-1:0];
        meta_wdata = '{free_head: 1'b1, order: ord};
      end
      S_U_STEP: begin
        link_raddr = cur[bpa_pkg::PAGE_W-1:0];
      end
      S_U_READ: begin
        link_we    = (cur[bpa_pkg::PAGE_W-1:0] == bud) && !prev[bpa_pkg::PAGE_W];
        link_waddr = prev[bpa_pkg::PAGE_W-1:0];
        link_wdata = link_rdata;
      end
      S_U_CLR: begin
        link_we    = 1'b1;
        link_waddr = cur[bpa_pkg::PAGE_W-1:0];
        meta_we    = 1'b1;
        meta_waddr = cur[bpa_pkg::PAGE_W-1:0];
        meta_wdata = '{free_head: 1'b0, order: ord};
      end
      S_F_PUSH: begin
        link_we    = (pg != '0);
        link_wdata = head_o;
        meta_we    = (pg != '0);
        meta_wdata = '{free_head: 1'b1, order: ord};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      total   <= '0;
      for (int i = 0; i < bpa_pkg::ORDERS; i++) begin
        heads[i] <= bpa_pkg::EMPTY;
        lens[i]  <= '0;
      end
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            ord        <= req.block_order;
            tgt        <= req.block_order;
            pg         <= req.page_number;
            top_eff    <= top_c;
            zend       <= zend_c;
            res_page   <= '0;
            res_status <= bpa_pkg::ST_DONE;
            if (req.block_order > top_c) begin
              res_status <= bpa_pkg::ST_BAD_ORD;
              state      <= S_DONE;
            end else if (req.action == bpa_pkg::ACT_ALLOC) begin
              state <= S_A_SCAN;
            end else begin
              state <= S_F_CHK;
            end
          end
        end
        S_A_SCAN: begin
          if (ord > top_eff) begin
            res_status <= bpa_pkg::ST_NO_FIT;
            state      <= S_DONE;
          end else if (head_o[bpa_pkg::PAGE_W]) begin
            ord <= ord + 1'b1;
          end else begin
            pg    <= head_o[bpa_pkg::PAGE_W-1:0];
            state <= S_A_POP;
          end
        end
        S_A_POP: begin
          heads[oi] <= link_rdata;
          if (len_o != '0) begin
            lens[oi] <= len_o - 1'b1;
            total    <= total - osize;
          end
          if (pg == '0) begin
            ord   <= ord + 1'b1;
            state <= S_A_SCAN;
          end else if (ord == tgt) begin
            res_page <= pg;
            state    <= S_DONE;
          end else begin
            ord   <= ord - 1'b1;
            state <= S_A_SPLIT;
          end
        end
        S_A_SPLIT: begin
          if (!split_pg[bpa_pkg::PAGE_W]) begin
            heads[oi] <= split_pg;
            lens[oi]  <= len_o + 1'b1;
            total     <= total + osize;
          end
          if (ord == tgt) begin
            res_page <= pg;
            state    <= S_DONE;
          end else begin
            ord <= ord - 1'b1;
          end
        end
        S_F_CHK: begin
          bud <= bud_c;
          if (ord >= top_eff || !bud_ok) begin
            state <= S_F_TRIM;
          end else begin
            state <= S_F_META;
          end
        end
        S_F_META: begin
          if (!meta_rdata.free_head || meta_rdata.order != ord) begin
            state <= S_F_TRIM;
          end else begin
            cur   <= head_o;
            prev  <= bpa_pkg::EMPTY;
            steps <= '0;
            state <= S_U_STEP;
          end
        end
        S_U_STEP: begin
          if (cur[bpa_pkg::PAGE_W] || steps[bpa_pkg::PAGE_W]) begin
            pg    <= base_c;
            ord   <= ord + 1'b1;
            state <= S_F_CHK;
          end else begin
            state <= S_U_READ;
          end
        end
        S_U_READ: begin
          if (cur[bpa_pkg::PAGE_W-1:0] == bud) begin
            if (prev[bpa_pkg::PAGE_W]) begin
              heads[oi] <= link_rdata;
            end
            state <= S_U_CLR;
          end else begin
            prev  <= cur;
            cur   <= link_rdata;
            steps <= steps + 1'b1;
            state <= S_U_STEP;
          end
        end
        S_U_CLR: begin
          if (len_o != '0) begin
            lens[oi] <= len_o - 1'b1;
            total    <= total - osize;
          end
          pg    <= base_c;
          ord   <= ord + 1'b1;
          state <= S_F_CHK;
        end
        S_F_TRIM: begin
          if (ord != '0 && trim_end > zend) begin
            ord <= ord - 1'b1;
          end else begin
            state <= S_F_PUSH;
          end
        end
        S_F_PUSH: begin
          if (pg != '0) begin
            heads[oi] <= {1'b0, pg};
            lens[oi]  <= len_o + 1'b1;
            total     <= total + osize;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = '{status: res_status, granted_page: res_page, free_page_total: total};

endmodule

>>> design/buddy_page_allocator_core.sv
// Buddy page allocator for one zone of 4096 pages. After reset the page
// metadata ram is swept clear with s_tready low; config writes are taken
// at any time. Each transaction then runs on a sequencer around two rams
// with one read and one write port each (list links and per-page
// metadata): an allocate scans past empty orders, drops zero-page heads
// and splits down to the asked order; a free merges with its buddy while
// it can, walking the list to unlink the buddy, then trims the order to
// fit the zone and pushes the block. A finished result sits in the output
// register, so a new request is taken while it waits.
// depends on bpa_pkg and bpa_engine
module buddy_page_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // block_order[3:0], page_number[15:4]
  input  logic [0:0]                    s_tuser,   // action[0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,   // granted_page[11:0], free_page_total[24:12]
  output logic [1:0]                    m_tuser,   // status[1:0]
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpa_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [bpa_pkg::CDATA_W-1:0]   cfg_data
);

  bpa_pkg::cfg_t cfg;
  bpa_pkg::req_t req;
  bpa_pkg::res_t res, out_res;
  logic          eng_idle, res_valid, res_ready, start;

  assign cfg_ready = 1'b1;
  assign s_tready  = eng_idle;
  assign start     = s_tvalid & eng_idle;
  assign res_ready = !m_tvalid || m_tready;

  assign req.action      = bpa_pkg::action_t'(s_tuser[0]);
  assign req.block_order = s_tdata[3:0];
  assign req.page_number = s_tdata[15:4];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zone_first_page <= '0;
      cfg.zone_page_count <= bpa_pkg::LINK_W'(bpa_pkg::PAGES);
      cfg.top_order       <= bpa_pkg::ORD_W'(10);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bpa_pkg::REG_ZONE_FIRST: cfg.zone_first_page <= cfg_data[bpa_pkg::PAGE_W-1:0];
        bpa_pkg::REG_ZONE_COUNT: cfg.zone_page_count <= cfg_data[bpa_pkg::LINK_W-1:0];
        bpa_pkg::REG_TOP_ORDER:  cfg.top_order       <= cfg_data[bpa_pkg::ORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bpa_engine u_engine (
    .clk(clk), .rst(rst), .start(start), .req(req), .cfg(cfg),
    .idle(eng_idle), .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'd0, out_res.free_page_total, out_res.granted_page};
  assign m_tuser = out_res.status;

endmodule
